### rtl/core/pps_pkg.sv
// Shared types, codes and constants of the palette pixel serializer.
package pps_pkg;

	// Most pixels that one video byte can produce.
	localparam int unsigned PIX_MAX = 8;
	localparam int unsigned COLOUR_W = 3;
	localparam int unsigned LOGICAL_W = 4;
	localparam int unsigned PAL_DEPTH = 16;
	localparam int unsigned FIFO_DEPTH_DEF = 2;

	typedef logic [COLOUR_W-1:0] colour_t;
	typedef logic [LOGICAL_W-1:0] logical_t;
	typedef logic [$clog2(PIX_MAX)-1:0] pix_idx_t;

	localparam colour_t COLOUR_MASK = colour_t'(3'h7);

	// Item function codes.
	typedef enum logic [1:0] {
		FUNC_CONTROL = 2'd0,
		FUNC_PALETTE = 2'd1,
		FUNC_PIXEL   = 2'd2,
		FUNC_FLASH   = 2'd3
	} func_t;

	// Display modes from control bits 3-2.
	typedef enum logic [1:0] {
		MODE_1BPP   = 2'd0,
		MODE_2BPP   = 2'd1,
		MODE_4BPP   = 2'd2,
		MODE_NIBBLE = 2'd3
	} mode_t;

	// Kind of work handed from the front to the back.
	typedef enum logic {
		KIND_PIXELS  = 1'b0,
		KIND_PALETTE = 1'b1
	} kind_t;

	// One queued job: a classified video byte or a palette update.
	typedef struct packed {
		kind_t                    kind;
		logical_t [PIX_MAX-1:0]   logical;
		pix_idx_t                 last_idx;
		logic                     invert;
		logical_t                 pal_idx;
		colour_t                  pal_val;
	} job_t;

endpackage

### rtl/core/pps_if.sv
// Valid/ready channel interfaces for items and for pixel results.
interface pps_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] video_byte;
	logic       cursor_on;

	modport source (output valid, func, video_byte, cursor_on, input ready);
	modport sink (input valid, func, video_byte, cursor_on, output ready);
endinterface

interface pps_pixel_if;
	logic       valid;
	logic       ready;
	logic [2:0] pixel_colour;
	logic       last_pixel;

	modport source (output valid, pixel_colour, last_pixel, input ready);
	modport sink (input valid, pixel_colour, last_pixel, output ready);
endinterface

### rtl/core/palette_pixel_serializer.sv
// Top level of the palette pixel serializer.
// A video byte yields 8, 4, 2 or 1 pixels in modes 0 to 3, and the back end
// sends them one pixel per cycle through the palette lookup while the output
// is not stalled. A palette write is done in the back end and gives no output;
// control writes and flash toggles are taken in the front end and never reach
// the back end. A job queue of FIFO_DEPTH entries (two by default) lets the
// front accept new items while the back is still emitting pixels or waiting
// on a stalled output.
module palette_pixel_serializer
	import pps_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pps_item_if.sink     item,
	pps_pixel_if.source  result
);

	job_t job_data;
	job_t job_head;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_empty;

	// Classification and control register.
	pps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.job_full (job_full),
		.job_push (job_push),
		.job_data (job_data)
	);

	// Job queue.
	pps_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_data),
		.full      (job_full),
		.pop       (job_pop),
		.head      (job_head),
		.empty     (job_empty)
	);

	// Palette and pixel serializer.
	pps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (job_head),
		.empty  (job_empty),
		.pop    (job_pop),
		.result (result)
	);

endmodule

### rtl/core/pps_front.sv
// Front end: accepts items, keeps the control byte and classifies video bytes.
module pps_front
	import pps_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pps_item_if.sink      item,
	input  logic          job_full,
	output logic          job_push,
	output job_t          job_data
);

	logic [7:0] control_q;
	func_t      func;
	mode_t      mode;
	logic       accept;

	assign func   = func_t'(item.func);
	assign mode   = mode_t'(control_q[3:2]);
	assign accept = item.valid && item.ready;

	// Items are taken whenever the job queue has room.
	assign item.ready = !job_full;
	assign job_push   = accept && (func == FUNC_PIXEL || func == FUNC_PALETTE);

	// Build the job: pixel logical colours per mode, or the palette update.
	always_comb begin
		job_data          = '0;
		job_data.kind     = (func == FUNC_PALETTE) ? KIND_PALETTE : KIND_PIXELS;
		job_data.invert   = item.cursor_on;
		job_data.pal_idx  = item.video_byte[7:4];
		job_data.pal_val  = ~item.video_byte[2:0];
		case (mode)
			MODE_1BPP: begin
				for (int i = 0; i < 8; i++) begin
					job_data.logical[i] = {3'b000, item.video_byte[7-i]};
				end
				job_data.last_idx = pix_idx_t'(7);
			end
			MODE_2BPP: begin
				for (int i = 0; i < 4; i++) begin
					job_data.logical[i] = {2'b00, item.video_byte[7-i], item.video_byte[3-i]};
				end
				job_data.last_idx = pix_idx_t'(3);
			end
			MODE_4BPP: begin
				for (int i = 0; i < 2; i++) begin
					job_data.logical[i] = {item.video_byte[7-i], item.video_byte[5-i],
						item.video_byte[3-i], item.video_byte[1-i]};
				end
				job_data.last_idx = pix_idx_t'(1);
			end
			default: begin
				job_data.logical[0] = item.video_byte[3:0];
				job_data.last_idx   = pix_idx_t'(0);
			end
		endcase
	end

	// Control byte: full writes and the flash bit toggle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
		end else if (accept) begin
			case (func)
				FUNC_CONTROL: begin
					control_q <= item.video_byte;
				end
				FUNC_FLASH: begin
					control_q[0] <= ~control_q[0];
				end
				default: begin
					control_q <= control_q;
				end
			endcase
		end
	end

endmodule

### rtl/core/pps_fifo.sv
// Short show-ahead job queue between the front and the back.
module pps_fifo
	import pps_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/pps_back.sv
// Back end: owns the palette; sends one pixel per cycle unless stalled.
module pps_back
	import pps_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          head,
	input  logic          empty,
	output logic          pop,
	pps_pixel_if.source   result
);

	colour_t  palette_q [PAL_DEPTH];
	pix_idx_t pos_q;
	logic     valid_q;
	colour_t  colour_q;
	logic     last_q;
	logic     advance;
	logic     at_last;

	assign advance = !empty && (!valid_q || result.ready);
	assign at_last = (pos_q == head.last_idx);
	assign pop     = advance && (head.kind == KIND_PALETTE || at_last);

	assign result.valid        = valid_q;
	assign result.pixel_colour = colour_q;
	assign result.last_pixel   = last_q;

	// Palette: entry n resets to n mod 8, updated in queue order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < PAL_DEPTH; n++) begin
				palette_q[n] <= colour_t'(n);
			end
		end else if (advance && head.kind == KIND_PALETTE) begin
			palette_q[head.pal_idx] <= head.pal_val;
		end
	end

	// Pixel position within the current byte and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance && head.kind == KIND_PIXELS) begin
				pos_q   <= at_last ? '0 : pos_q + pix_idx_t'(1);
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload: palette lookup, cursor inversion and last flag.
	always_ff @(posedge clk) begin
		if (advance && head.kind == KIND_PIXELS) begin
			colour_q <= palette_q[head.logical[pos_q]] ^ (head.invert ? COLOUR_MASK : '0);
			last_q   <= at_last;
		end
	end

endmodule
